FILE: hdl/move_to_front_price_cache_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the price cache.
// ----------------------------------------------------------------------------
`ifndef MOVE_TO_FRONT_PRICE_CACHE_ASSERT_SVH
`define MOVE_TO_FRONT_PRICE_CACHE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define MTFPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define MTFPC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle check that also runs while reset is applied.
`define MTFPC_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: hdl/mtfpc_pkg.sv
// ----------------------------------------------------------------------------
// mtfpc_pkg
// Shared types and codes for the move-to-front price cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtfpc_pkg;

    localparam int DATA_W  = 32;
    localparam int SLOT_OW = 7;

    // request kinds carried in s_tuser
    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_CHANGE = 1'b1;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_MOVE,
        OP_SETP
    } cell_op_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              cmp_en;
        cell_op_t          op;
        logic [DATA_W-1:0] code;
        logic [DATA_W-1:0] price;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/mtfpc_cell.sv
// ----------------------------------------------------------------------------
// mtfpc_cell
// One recency slot: key and price, local compare, takes its lower neighbor's
// entry on a move.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtfpc_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mtfpc_pkg::cell_ctrl_t      ctrl,
    input  logic [CNT_W-1:0]           limit,
    input  logic [CNT_W-1:0]           fill,
    input  logic [mtfpc_pkg::DATA_W-1:0] prev_key,
    input  logic [mtfpc_pkg::DATA_W-1:0] prev_price,
    output logic [mtfpc_pkg::DATA_W-1:0] key,
    output logic [mtfpc_pkg::DATA_W-1:0] price,
    output logic                       match
);
    import mtfpc_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [DATA_W-1:0] key_reg, key_next;
    logic [DATA_W-1:0] price_reg, price_next;
    logic              match_reg, match_next;

    always_comb begin
        key_next   = key_reg;
        price_next = price_reg;
        match_next = match_reg;
        // only slots below the fill count hold written entries
        if (ctrl.cmp_en) begin
            match_next = (MY_IDX < fill) && (key_reg == ctrl.code);
        end
        unique case (ctrl.op)
            OP_HOLD: begin
            end
            OP_MOVE: begin
                if (MY_IDX == '0) begin
                    key_next   = ctrl.code;
                    price_next = ctrl.price;
                end else if (MY_IDX <= limit) begin
                    key_next   = prev_key;
                    price_next = prev_price;
                end
            end
            OP_SETP: begin
                if (MY_IDX == limit) begin
                    price_next = ctrl.price;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        price_reg <= price_next;
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign key   = key_reg;
    assign price = price_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

FILE: hdl/mtfpc_enc.sv
// ----------------------------------------------------------------------------
// mtfpc_enc
// Folds the per-cell match flags into hit, slot and hit price. Keys are
// unique, so at most one flag is set and a plain OR reduction suffices.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtfpc_enc #(
    parameter int ENTRIES = 128,
    parameter int IDX_W   = 7
) (
    input  logic [ENTRIES-1:0]             match,
    input  logic [mtfpc_pkg::DATA_W-1:0]   price [ENTRIES],
    output logic                           hit,
    output logic [IDX_W-1:0]               slot,
    output logic [mtfpc_pkg::DATA_W-1:0]   hit_price
);
    import mtfpc_pkg::*;

    always_comb begin
        hit       = 1'b0;
        slot      = '0;
        hit_price = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit       = hit | match[i];
            slot      = slot | (match[i] ? IDX_W'(i) : '0);
            hit_price = hit_price | (match[i] ? price[i] : '0);
        end
    end

endmodule

`default_nettype wire

FILE: hdl/move_to_front_price_cache.sv
// A request word is accepted only in idle and then passes through the compare,
// encode and update states in order; the result word is loaded by the update,
//   which waits while a stalled result word is still held. No new request is taken until then.
// The steps come from the cell row: compare in every cell, OR-encode, one shift or rewrite.
// Reset (aresetn low, synchronous): cache empty, no result pending.
// ----------------------------------------------------------------------------
// move_to_front_price_cache
// Recency-ordered code-to-price cache built as a row of cells, slot 0 most
// recent. Access: hit moves the entry to the front, miss inserts the given
// price at the front and drops the oldest entry when full. Change: rewrites
// the price of a cached code in place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_price_cache #(
    parameter int ENTRIES = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] item_code, [63:32] price_value
    input  logic [0:0]  s_tuser,   // [0] req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] front_price, [38:32] hit_slot, [39] zero
    output logic [0:0]  m_tuser    // [0] was_hit
);
    import mtfpc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int EXT_W = IDX_W + SLOT_OW;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,   // waiting for a request word
        ST_CMP,    // every cell compares its key
        ST_ENC,    // match flags folded into hit / slot / price
        ST_UPD     // cells shift or rewrite, result word loaded
    } state_t;

    state_t state_reg;

    // request held for the whole sequence
    logic              kind_reg;
    logic [DATA_W-1:0] code_reg;
    logic [DATA_W-1:0] price_reg;

    // encoder results
    logic              hit_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [DATA_W-1:0] hprice_reg;

    logic [CNT_W-1:0]  fill_reg;

    logic              m_tvalid_reg;
    logic [DATA_W-1:0] front_reg;
    logic              was_hit_reg;
    logic [SLOT_OW-1:0] hit_slot_reg;

    // cell row
    cell_ctrl_t        ctrl;
    logic [CNT_W-1:0]  limit;
    logic [ENTRIES-1:0] match;
    logic [DATA_W-1:0] cell_key   [ENTRIES];
    logic [DATA_W-1:0] cell_price [ENTRIES];

    logic              enc_hit;
    logic [IDX_W-1:0]  enc_slot;
    logic [DATA_W-1:0] enc_price;

    logic              upd_go;
    logic [DATA_W-1:0] front_next;
    logic [EXT_W-1:0]  slot_ext;

    // result register free this cycle
    assign upd_go = (state_reg == ST_UPD) && (!m_tvalid_reg || m_tready);

    // an access writes the front with the found price on a hit, else the
    // supplied one; the move covers slots up to the hit slot or the fill
    always_comb begin
        ctrl.cmp_en = (state_reg == ST_CMP);
        ctrl.op     = OP_HOLD;
        ctrl.code   = code_reg;
        ctrl.price  = price_reg;
        limit       = hit_reg ? CNT_W'(slot_reg) : fill_reg;
        front_next  = '0;
        if (kind_reg == REQ_ACCESS) begin
            front_next = hit_reg ? hprice_reg : price_reg;
            ctrl.price = front_next;
            if (upd_go) begin
                ctrl.op = OP_MOVE;
            end
        end else if (hit_reg) begin
            front_next = price_reg;
            if (upd_go) begin
                ctrl.op = OP_SETP;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            logic [DATA_W-1:0] nb_key;
            logic [DATA_W-1:0] nb_price;
            if (g == 0) begin : g_head
                assign nb_key   = '0;
                assign nb_price = '0;
            end else begin : g_body
                assign nb_key   = cell_key[g-1];
                assign nb_price = cell_price[g-1];
            end
            mtfpc_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .limit      (limit),
                .fill       (fill_reg),
                .prev_key   (nb_key),
                .prev_price (nb_price),
                .key        (cell_key[g]),
                .price      (cell_price[g]),
                .match      (match[g])
            );
        end
    endgenerate

    mtfpc_enc #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_enc (
        .match     (match),
        .price     (cell_price),
        .hit       (enc_hit),
        .slot      (enc_slot),
        .hit_price (enc_price)
    );

    assign slot_ext = EXT_W'(slot_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // loaded when the update fires, else held until taken
            m_tvalid_reg <= upd_go || (m_tvalid_reg && !m_tready);
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg  <= s_tuser[0];
                        code_reg  <= s_tdata[31:0];
                        price_reg <= s_tdata[63:32];
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    state_reg <= ST_ENC;
                end
                ST_ENC: begin
                    hit_reg    <= enc_hit;
                    slot_reg   <= enc_slot;
                    hprice_reg <= enc_price;
                    state_reg  <= ST_UPD;
                end
                ST_UPD: begin
                    if (upd_go) begin
                        front_reg    <= front_next;
                        was_hit_reg  <= hit_reg;
                        hit_slot_reg <= hit_reg ? slot_ext[SLOT_OW-1:0] : '0;
                        if ((kind_reg == REQ_ACCESS) && !hit_reg && (fill_reg != FULL)) begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, hit_slot_reg, front_reg};
    assign m_tuser  = was_hit_reg;

endmodule

`default_nettype wire

FILE: hdl/mtfpc_chk.sv
// ----------------------------------------------------------------------------
// mtfpc_chk
// Port-level checks on the price cache, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "move_to_front_price_cache_assert.svh"

module mtfpc_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a held result word stays offered until taken
    `MTFPC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // one request at a time: no accept right after an accept
    `MTFPC_ASSERT_NEXT(a_one_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // a miss reports slot zero
    `MTFPC_ASSERT_SAME(a_miss_slot, aclk, aresetn, m_tvalid && !m_tuser[0],
                       m_tdata[38:32] == 7'd0)

    // reset drops any pending result word
    `MTFPC_ASSERT_ALWAYS(a_rst_out, aclk, !aresetn, !m_tvalid)

endmodule

bind move_to_front_price_cache mtfpc_chk u_mtfpc_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
